@@ hw/rtl/clcd_pkg.sv @@
// clcd_pkg: shared types and constants for the character-LCD bus write sequencer.
// No dependencies; all other files but clcd_checker refer to it by scoped names.
`default_nettype none

package clcd_pkg;

    localparam int unsigned HOLD_W = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_BUS_EIGHT_BIT       = 2'd0;
    localparam logic [1:0] CFG_NIBBLE_ON_HIGH_HALF = 2'd1;
    localparam logic [1:0] CFG_PHASE_HOLD_CYCLES   = 2'd2;

    localparam logic       RST_BUS_EIGHT_BIT       = 1'b1;
    localparam logic       RST_NIBBLE_ON_HIGH_HALF = 1'b1;
    localparam logic [HOLD_W-1:0] RST_PHASE_HOLD_CYCLES = 24'd50000;

    localparam logic [7:0] NIB_HI_MASK = 8'hF0;
    localparam logic [7:0] NIB_LO_MASK = 8'h0F;

    // one classified write, as queued between front and back
    typedef struct packed {
        logic       rs;         // register select level for the write
        logic       eight_bit;  // five-state 8-bit transfer
        logic [7:0] hi_bus;     // bus level of the first (or only) data transfer
        logic [7:0] lo_bus;     // bus level of the second nibble transfer
    } cmd_t;

    // pin state sequence, one-hot
    typedef enum logic [7:0] {
        ST_SELECT   = 8'b0000_0001,
        ST_EN_HI    = 8'b0000_0010,
        ST_DATA_HI  = 8'b0000_0100,
        ST_EN_LO    = 8'b0000_1000,
        ST_EN_HI2   = 8'b0001_0000,
        ST_DATA_LO  = 8'b0010_0000,
        ST_EN_LO2   = 8'b0100_0000,
        ST_CLEAR    = 8'b1000_0000
    } step_t;

    // one pin state beat
    typedef struct packed {
        logic       rs;
        logic       en;
        logic [7:0] bus;
        logic       last;
    } pins_t;

endpackage

`default_nettype wire

@@ hw/rtl/clcd_front.sv @@
// clcd_front: accepts write beats and classifies them into queued commands.
// Depends on clcd_pkg (cmd_t, nibble masks).
`default_nettype none

module clcd_front
(
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,      // [7:0] value
    input  wire logic          s_tuser,      // [0] operation
    input  wire logic          bus_eight_bit,
    input  wire logic          nibble_on_high_half,
    output logic               push_valid,
    input  wire logic          push_ready,
    output clcd_pkg::cmd_t     push_cmd
);

    logic [7:0] hi_placed;
    logic [7:0] lo_placed;

    always_comb
    begin
        if (nibble_on_high_half)
        begin
            hi_placed = s_tdata & clcd_pkg::NIB_HI_MASK;
            lo_placed = {s_tdata[3:0], 4'b0000};
        end
        else
        begin
            hi_placed = {4'b0000, s_tdata[7:4]};
            lo_placed = s_tdata & clcd_pkg::NIB_LO_MASK;
        end
    end

    always_comb
    begin
        push_cmd.rs        = s_tuser;
        push_cmd.eight_bit = bus_eight_bit;
        push_cmd.hi_bus    = bus_eight_bit ? s_tdata : hi_placed;
        push_cmd.lo_bus    = lo_placed;
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

@@ hw/rtl/clcd_fifo.sv @@
// clcd_fifo: short command queue between the front and the back.
// Depends on clcd_pkg (cmd_t).
`default_nettype none

module clcd_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  clcd_pkg::cmd_t      push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output clcd_pkg::cmd_t      pop_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    clcd_pkg::cmd_t  mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/clcd_back.sv @@
// clcd_back: steps each queued command through its pin states, spacing the
// states by phase_hold_cycles. Depends on clcd_pkg (cmd_t, step_t, pins_t).
`default_nettype none

module clcd_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [clcd_pkg::HOLD_W-1:0]   phase_hold_cycles,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  clcd_pkg::cmd_t                     pop_cmd,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output clcd_pkg::pins_t                    m_pins
);

    clcd_pkg::cmd_t  cur_reg;
    clcd_pkg::cmd_t  cmd;
    clcd_pkg::step_t step_reg, step_next;
    clcd_pkg::pins_t beat;
    clcd_pkg::pins_t pins_reg;
    logic            busy_reg, busy_next;
    logic            out_valid_reg, out_valid_next;
    logic [clcd_pkg::HOLD_W-1:0] hold_reg, hold_next, hold_load;
    logic            slot_free, emit;

    assign cmd       = busy_reg ? cur_reg : pop_cmd;
    assign slot_free = !out_valid_reg || m_tready;
    assign emit      = slot_free && (hold_reg == '0) && (busy_reg || pop_valid);
    assign pop_ready = emit && !busy_reg;
    // a hold of zero behaves as one
    assign hold_load = (phase_hold_cycles == '0) ? '0
                                                 : phase_hold_cycles - clcd_pkg::HOLD_W'(1);

    always_comb
    begin
        beat.rs   = cmd.rs;
        beat.en   = 1'b0;
        beat.bus  = 8'h00;
        beat.last = 1'b0;
        step_next = step_reg;
        unique case (step_reg)
            clcd_pkg::ST_SELECT:
            begin
                step_next = clcd_pkg::ST_EN_HI;
            end
            clcd_pkg::ST_EN_HI:
            begin
                beat.en   = 1'b1;
                step_next = clcd_pkg::ST_DATA_HI;
            end
            clcd_pkg::ST_DATA_HI:
            begin
                beat.en   = 1'b1;
                beat.bus  = cmd.hi_bus;
                step_next = clcd_pkg::ST_EN_LO;
            end
            clcd_pkg::ST_EN_LO:
            begin
                beat.bus  = cmd.hi_bus;
                step_next = cmd.eight_bit ? clcd_pkg::ST_CLEAR : clcd_pkg::ST_EN_HI2;
            end
            clcd_pkg::ST_EN_HI2:
            begin
                // strobe rises again with the high nibble still on the bus
                beat.en   = 1'b1;
                beat.bus  = cmd.hi_bus;
                step_next = clcd_pkg::ST_DATA_LO;
            end
            clcd_pkg::ST_DATA_LO:
            begin
                beat.en   = 1'b1;
                beat.bus  = cmd.lo_bus;
                step_next = clcd_pkg::ST_EN_LO2;
            end
            clcd_pkg::ST_EN_LO2:
            begin
                beat.bus  = cmd.lo_bus;
                step_next = clcd_pkg::ST_CLEAR;
            end
            clcd_pkg::ST_CLEAR:
            begin
                beat.rs   = 1'b0;
                beat.last = 1'b1;
                step_next = clcd_pkg::ST_SELECT;
            end
            default:
            begin
                step_next = clcd_pkg::ST_SELECT;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        hold_next      = hold_reg;
        if (hold_reg != '0)
        begin
            hold_next = hold_reg - clcd_pkg::HOLD_W'(1);
        end
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            hold_next      = hold_load;
            busy_next      = (step_reg != clcd_pkg::ST_CLEAR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= clcd_pkg::ST_SELECT;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
            if (emit)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready)
        begin
            cur_reg <= pop_cmd;
        end
        if (emit)
        begin
            pins_reg <= beat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_pins   = pins_reg;

endmodule

`default_nettype wire

@@ hw/rtl/char_lcd_bus_write_sequencer_top.sv @@
// char_lcd_bus_write_sequencer_top: character-LCD bus write sequencer.
// Depends on clcd_pkg, clcd_front, clcd_fifo and clcd_back.
//
//  channel   direction  signals                     contents
//  s_*       in         tvalid tready tdata tuser   one byte write per beat
//  m_*       out        tvalid tready tdata tuser   one pin state per beat
//                       tlast
//  cfg_*     in         wr_en addr wdata            mode and hold registers
//
// An 8-bit write gives 5 pin-state beats, a 4-bit write 8. Consecutive beats
// leave the back end paced by phase_hold_cycles (a hold of 0 behaves as 1)
// and by any m_tready stall; the state stepper in the back end sets that
// pacing. The front end keeps accepting into a FIFO_DEPTH queue while the
// back end steps or m_tready is low, until that queue is full.
// Reset clears the queue, the stepper and the output valid; the registers
// return to 8-bit mode, nibble on bits 7..4 and a hold of 50000.
`default_nettype none

module char_lcd_bus_write_sequencer_top
#(
    parameter int unsigned FIFO_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] value
    input  wire logic        s_tuser,     // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // [0] enable_pin, [8:1] bus_pins, [15:9] zero
    output logic             m_tuser,     // [0] reg_select
    output logic             m_tlast,     // last_state
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata
);

    logic                        bus8_reg;
    logic                        hi_half_reg;
    logic [clcd_pkg::HOLD_W-1:0] hold_reg;

    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;
    clcd_pkg::cmd_t  push_cmd, pop_cmd;
    clcd_pkg::pins_t pins;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus8_reg    <= clcd_pkg::RST_BUS_EIGHT_BIT;
            hi_half_reg <= clcd_pkg::RST_NIBBLE_ON_HIGH_HALF;
            hold_reg    <= clcd_pkg::RST_PHASE_HOLD_CYCLES;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                clcd_pkg::CFG_BUS_EIGHT_BIT:       bus8_reg    <= cfg_wdata[0];
                clcd_pkg::CFG_NIBBLE_ON_HIGH_HALF: hi_half_reg <= cfg_wdata[0];
                clcd_pkg::CFG_PHASE_HOLD_CYCLES:   hold_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    clcd_front u_front
    (
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .bus_eight_bit       (bus8_reg),
        .nibble_on_high_half (hi_half_reg),
        .push_valid          (push_valid),
        .push_ready          (push_ready),
        .push_cmd            (push_cmd)
    );

    clcd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    clcd_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .phase_hold_cycles (hold_reg),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_cmd           (pop_cmd),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_pins            (pins)
    );

    assign m_tdata = {7'b000_0000, pins.bus, pins.en};
    assign m_tuser = pins.rs;
    assign m_tlast = pins.last;

endmodule

`default_nettype wire

@@ hw/rtl/clcd_checker.sv @@
// clcd_checker: port-level assertions for the sequencer's output stream,
// bound to char_lcd_bus_write_sequencer_top. No package dependencies.
`default_nettype none

module clcd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a stalled beat keeps its contents
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output beat changed");

    // the closing state leaves every pin low
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata == 16'h0000) && !m_tuser)
        else $error("last pin state not cleared");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] == 7'd0))
        else $error("tdata pad bits set");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind char_lcd_bus_write_sequencer_top clcd_checker u_clcd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for char_lcd_bus_write_sequencer_top.
// Predicts the pin-state beats of each byte write and checks every m_* beat.
// Depends on clcd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_STALL  = 400;

    // expected pin states of accepted writes, in order, with the register copy
    class pin_state_board;
        logic                        eight_bit;
        logic                        high_half;
        logic [clcd_pkg::HOLD_W-1:0] hold;
        clcd_pkg::pins_t             pending_states[$];
        int                          errors;
        int                          writes;
        int                          states_seen;

        function new();
            eight_bit   = clcd_pkg::RST_BUS_EIGHT_BIT;
            high_half   = clcd_pkg::RST_NIBBLE_ON_HIGH_HALF;
            hold        = clcd_pkg::RST_PHASE_HOLD_CYCLES;
            errors      = 0;
            writes      = 0;
            states_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                clcd_pkg::CFG_BUS_EIGHT_BIT:       eight_bit = data[0];
                clcd_pkg::CFG_NIBBLE_ON_HIGH_HALF: high_half = data[0];
                clcd_pkg::CFG_PHASE_HOLD_CYCLES:   hold      = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] place(logic [3:0] nib);
            return high_half ? {nib, 4'h0} : {4'h0, nib};
        endfunction

        function void push(logic rs, logic en, logic [7:0] bus, logic last);
            clcd_pkg::pins_t p;
            p.rs   = rs;
            p.en   = en;
            p.bus  = bus;
            p.last = last;
            pending_states.push_back(p);
        endfunction

        // one accepted byte write
        function void log_write(logic op, logic [7:0] value);
            logic [7:0] hi;
            logic [7:0] lo;
            writes++;
            push(op, 1'b0, 8'h00, 1'b0);
            push(op, 1'b1, 8'h00, 1'b0);
            if (eight_bit)
            begin
                push(op, 1'b1, value, 1'b0);
                push(op, 1'b0, value, 1'b0);
            end
            else
            begin
                hi = place(value[7:4]);
                lo = place(value[3:0]);
                push(op, 1'b1, hi, 1'b0);
                push(op, 1'b0, hi, 1'b0);
                push(op, 1'b1, hi, 1'b0);
                push(op, 1'b1, lo, 1'b0);
                push(op, 1'b0, lo, 1'b0);
            end
            push(1'b0, 1'b0, 8'h00, 1'b1);
        endfunction

        function void check_state(clcd_pkg::pins_t got, logic [6:0] pad);
            clcd_pkg::pins_t want;
            states_seen++;
            if (pending_states.size() == 0)
            begin
                $error("pin state beat with nothing expected: rs=%0d en=%0d bus=%02h last=%0d",
                       got.rs, got.en, got.bus, got.last);
                errors++;
                return;
            end
            want = pending_states.pop_front();
            if (got.rs !== want.rs)
            begin
                $error("reg_select: expected %0d, got %0d", want.rs, got.rs);
                errors++;
            end
            if (got.en !== want.en)
            begin
                $error("enable_pin: expected %0d, got %0d", want.en, got.en);
                errors++;
            end
            if (got.bus !== want.bus)
            begin
                $error("bus_pins: expected %02h, got %02h", want.bus, got.bus);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_state: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (pad !== 7'd0)
            begin
                $error("m_tdata padding: expected 0, got %02h", pad);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [23:0] cfg_wdata;

    pin_state_board board;
    int  cycles;
    int  burst_left;
    bit  steady;          // sender offers back to back, no gaps
    bit  long_stall_req;  // receiver holds m_tready low for a LONG_STALL stretch
    int  phases_run;

    char_lcd_bus_write_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL char_lcd_bus_write_sequencer_top");
                $finish;
            end
        end
    end

    // beat monitor: values read here are the ones present before the edge
    always @(posedge clk)
    begin
        clcd_pkg::pins_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.log_write(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.rs   = m_tuser;
                got.en   = m_tdata[0];
                got.bus  = m_tdata[8:1];
                got.last = m_tlast;
                board.check_state(got, m_tdata[15:9]);
            end
        end
    end

    // receiver: random ready pattern, all-ready stretches, one long hold-off
    initial
    begin
        logic [15:0] pattern;
        int          pat_left;
        pat_left = 0;
        pattern  = '1;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                m_tready = 1'b0;
                repeat (LONG_STALL) @(negedge clk);
                long_stall_req = 1'b0;
                pat_left = 0;
            end
            if (pat_left == 0)
            begin
                pattern  = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                       : 16'($urandom | $urandom);
                pat_left = 16;
            end
            m_tready = pattern[0];
            pattern  = {pattern[0], pattern[15:1]};
            pat_left--;
        end
    end

    task automatic send_write(input logic op, input logic [7:0] value);
        int gap;
        if (burst_left == 0 && !steady)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // stop offering and let every expected beat drain, then the back end settle
    task automatic drain();
        @(negedge clk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (board.pending_states.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_mode(input logic eight, input logic high, input logic [23:0] hold);
        drain();
        cfg_write(clcd_pkg::CFG_BUS_EIGHT_BIT, {23'd0, eight});
        cfg_write(clcd_pkg::CFG_NIBBLE_ON_HIGH_HALF, {23'd0, high});
        cfg_write(clcd_pkg::CFG_PHASE_HOLD_CYCLES, hold);
        phases_run++;
    endtask

    // corners of the byte, both kinds
    task automatic send_corners();
        send_write(1'b0, 8'hFF);
        send_write(1'b1, 8'h00);
        send_write(1'b1, 8'hF0);
        send_write(1'b0, 8'h0F);
    endtask

    initial
    begin
        logic [23:0] hold;
        int          n_items;
        board          = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tuser        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = clcd_pkg::CFG_BUS_EIGHT_BIT;
        cfg_wdata      = 24'd0;
        burst_left     = 0;
        steady         = 1'b0;
        long_stall_req = 1'b0;
        phases_run     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // largest hold is only parked, no write runs under it
        cfg_write(clcd_pkg::CFG_PHASE_HOLD_CYCLES, 24'hFFFFFF);

        // directed: 8-bit, shortest hold
        set_mode(1'b1, 1'b1, 24'd1);
        send_write(1'b0, 8'h00);
        send_write(1'b1, 8'hFF);
        send_write(1'b0, 8'h80);
        send_write(1'b1, 8'h01);
        send_write(1'b1, 8'hA5);
        send_write(1'b0, 8'h5A);
        // nibbles on the upper half
        set_mode(1'b0, 1'b1, 24'd2);
        send_corners();
        // nibbles on the lower half, zero hold
        set_mode(1'b0, 1'b0, 24'd0);
        send_corners();
        // mode flips between consecutive writes
        set_mode(1'b1, 1'b0, 24'd1);
        send_write(1'b1, 8'hC3);
        set_mode(1'b0, 1'b0, 24'd1);
        send_write(1'b1, 8'hC3);
        // long hold
        set_mode(1'b0, 1'b1, 24'd2000);
        send_write(1'b1, 8'h96);
        send_write(1'b0, 8'h69);

        // random phases
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       hold = 24'd0;
                1:       hold = 24'd1;
                default: hold = 24'($urandom_range(2, 6));
            endcase
            set_mode(1'($urandom), 1'($urandom), hold);
            n_items = $urandom_range(42, 56);
            if (ph == 2)
            begin
                // output held off while input is offered back to back
                long_stall_req = 1'b1;
                steady = 1'b1;
                for (int i = 0; i < 12; i++)
                    send_write(1'($urandom), 8'($urandom));
                steady = 1'b0;
                n_items -= 12;
            end
            for (int i = 0; i < n_items; i++)
                send_write(1'($urandom), 8'($urandom));
        end

        drain();
        repeat (int'(board.hold) + 20) @(posedge clk);
        if (board.pending_states.size() != 0)
        begin
            $error("%0d pin state beats never arrived", board.pending_states.size());
            board.errors++;
        end
        $display("Covered %0d byte writes over %0d mode/hold settings, %0d pin states checked.",
                 board.writes, phases_run, board.states_seen);
        if (board.errors == 0)
            $display("PASS char_lcd_bus_write_sequencer_top");
        else
            $display("FAIL char_lcd_bus_write_sequencer_top");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_front.sv
hw/rtl/clcd_fifo.sv
hw/rtl/clcd_back.sv
hw/rtl/char_lcd_bus_write_sequencer_top.sv
hw/rtl/clcd_checker.sv
tb/testbench.sv
